>>> rtl/vpri_pkg.sv
package vpri_pkg;

  // default sizes of the port block
  localparam int RegCountDef    = 64;
  localparam int VramAddrBitsDef = 17;
  localparam int PaletteEntries = 16;

  // fixed field widths
  localparam int VRAM_ADDR_W = 17;
  localparam int REG_NUM_W   = 6;
  localparam int PAL_IDX_W   = 4;
  localparam int COLOR_W     = 9;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 64;

  // registers that the port logic itself reads or writes
  localparam logic [REG_NUM_W-1:0] REG_VRAM_HI    = 6'd14;
  localparam logic [REG_NUM_W-1:0] REG_STATUS_SEL = 6'd15;
  localparam logic [REG_NUM_W-1:0] REG_PAL_INDEX  = 6'd16;

  // status register that carries the frame flag
  localparam logic [3:0] STATUS_FRAME = 4'd0;

  // access kinds
  typedef enum logic [2:0] {
    REQ_CTRL   = 3'd0,
    REQ_DATA   = 3'd1,
    REQ_PAL    = 3'd2,
    REQ_STATUS = 3'd3,
    REQ_TICK   = 3'd4
  } req_kind_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0]     pal_color;
    logic [PAL_IDX_W-1:0]   pal_entry;
    logic                   pal_we;
    logic [7:0]             reg_val;
    logic [REG_NUM_W-1:0]   reg_num;
    logic                   reg_we;
    logic [7:0]             vram_byte;
    logic [VRAM_ADDR_W-1:0] vram_addr;
    logic                   vram_we;
    logic [7:0]             read_data;
  } result_t;

endpackage

>>> rtl/vpri_in_reg.sv
module vpri_in_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [vpri_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [vpri_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                        advance,
  output logic                        item_vld,
  output vpri_pkg::req_t              item
);
  import vpri_pkg::*;

  logic valid_r;
  req_t item_r;

  // the slot frees when its item moves on to the result register; closed in reset
  assign in_tready = rst_n && (!valid_r || advance);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type  <= in_tuser;
      item_r.data_byte <= in_tdata;
    end
  end

  assign item_vld = valid_r;
  assign item     = item_r;

endmodule

>>> rtl/vpri_engine.sv
module vpri_engine #(
  parameter int REG_COUNT      = vpri_pkg::RegCountDef,
  parameter int VRAM_ADDR_BITS = vpri_pkg::VramAddrBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  vpri_pkg::req_t    item,
  input  logic              advance,
  output vpri_pkg::result_t res
);
  import vpri_pkg::*;

  localparam logic [REG_NUM_W:0] RegLimit = (REG_NUM_W+1)'(REG_COUNT);

  // port state
  logic                      pair_phase_r, pair_phase_nxt;
  logic [7:0]                pair_first_r, pair_first_nxt;
  logic [VRAM_ADDR_BITS-1:0] ptr_r, ptr_nxt;
  logic                      pal_phase_r, pal_phase_nxt;
  logic [7:0]                pal_first_r, pal_first_nxt;
  logic [PAL_IDX_W-1:0]      pal_index_r, pal_index_nxt;
  logic                      frame_flag_r, frame_flag_nxt;
  logic [2:0]                reg14_r, reg14_nxt;
  logic [3:0]                reg15_r, reg15_nxt;

  logic                      step;
  req_kind_t                 kind;
  logic [REG_NUM_W-1:0]      rnum;
  logic [VRAM_ADDR_W-1:0]    addr_load;
  logic [VRAM_ADDR_BITS-1:0] ptr_inc;
  logic [VRAM_ADDR_W-1:0]    ptr_inc_ext;

  assign step        = item_vld && advance;
  assign kind        = req_kind_t'(item.req_type);
  assign rnum        = item.data_byte[5:0];
  assign addr_load   = {reg14_r, item.data_byte[5:0], pair_first_r};
  assign ptr_inc     = ptr_r + 1'b1;
  assign ptr_inc_ext = VRAM_ADDR_W'(ptr_inc);

  // result and next state of one access
  always_comb begin
    res            = '0;
    pair_phase_nxt = pair_phase_r;
    pair_first_nxt = pair_first_r;
    ptr_nxt        = ptr_r;
    pal_phase_nxt  = pal_phase_r;
    pal_first_nxt  = pal_first_r;
    pal_index_nxt  = pal_index_r;
    frame_flag_nxt = frame_flag_r;
    reg14_nxt      = reg14_r;
    reg15_nxt      = reg15_r;
    unique case (kind)
      REQ_CTRL: begin
        if (!pair_phase_r) begin
          pair_first_nxt = item.data_byte;
          pair_phase_nxt = 1'b1;
        end else begin
          pair_phase_nxt = 1'b0;
          if (item.data_byte[7]) begin
            // register write from the latched byte
            if ({1'b0, rnum} < RegLimit) begin
              res.reg_we  = 1'b1;
              res.reg_num = rnum;
              res.reg_val = pair_first_r;
              if (rnum == REG_VRAM_HI) begin
                reg14_nxt = pair_first_r[2:0];
              end
              if (rnum == REG_STATUS_SEL) begin
                reg15_nxt = pair_first_r[3:0];
              end
              if (rnum == REG_PAL_INDEX) begin
                pal_index_nxt = pair_first_r[PAL_IDX_W-1:0];
                pal_phase_nxt = 1'b0;
              end
            end
          end else begin
            // address setup, high bits from register 14
            ptr_nxt = addr_load[VRAM_ADDR_BITS-1:0];
          end
        end
      end
      REQ_DATA: begin
        res.vram_we   = 1'b1;
        res.vram_addr = VRAM_ADDR_W'(ptr_r);
        res.vram_byte = item.data_byte;
        ptr_nxt       = ptr_inc;
        if (VRAM_ADDR_BITS > 14) begin
          reg14_nxt = ptr_inc_ext[16:14];
        end
      end
      REQ_PAL: begin
        if (!pal_phase_r) begin
          pal_first_nxt = item.data_byte;
          pal_phase_nxt = 1'b1;
        end else begin
          pal_phase_nxt = 1'b0;
          res.pal_we    = 1'b1;
          res.pal_entry = pal_index_r;
          res.pal_color = {pal_first_r[6:4], pal_first_r[2:0], item.data_byte[2:0]};
          pal_index_nxt = pal_index_r + 1'b1;
        end
      end
      REQ_STATUS: begin
        pair_phase_nxt = 1'b0;
        if (reg15_r == STATUS_FRAME) begin
          res.read_data  = {frame_flag_r, 7'b0};
          frame_flag_nxt = 1'b0;
        end
      end
      REQ_TICK: begin
        frame_flag_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // state registers, updated as each access leaves for the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_phase_r <= 1'b0;
      pair_first_r <= '0;
      ptr_r        <= '0;
      pal_phase_r  <= 1'b0;
      pal_first_r  <= '0;
      pal_index_r  <= '0;
      frame_flag_r <= 1'b0;
      reg14_r      <= '0;
      reg15_r      <= '0;
    end else if (step) begin
      pair_phase_r <= pair_phase_nxt;
      pair_first_r <= pair_first_nxt;
      ptr_r        <= ptr_nxt;
      pal_phase_r  <= pal_phase_nxt;
      pal_first_r  <= pal_first_nxt;
      pal_index_r  <= pal_index_nxt;
      frame_flag_r <= frame_flag_nxt;
      reg14_r      <= reg14_nxt;
      reg15_r      <= reg15_nxt;
    end
  end

  // checks
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld |-> $onehot0({res.vram_we, res.reg_we, res.pal_we}))
    else $error("more than one write kind in one access");

  a_tick_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && kind == REQ_TICK) |=> frame_flag_r)
    else $error("frame tick did not set the flag");

  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && kind == REQ_STATUS) |=> (!pair_phase_r && (!$past(reg15_r == STATUS_FRAME)
                                      || !frame_flag_r)))
    else $error("status read did not clear pair latch or frame flag");

  a_ptr_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (step && kind == REQ_DATA) |=> (ptr_r == $past(ptr_inc)))
    else $error("vram pointer did not advance after a data transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(ptr_r) && $stable(frame_flag_r) && $stable(pal_index_r)))
    else $error("state changed without an access");

endmodule

>>> rtl/vpri_out_reg.sv
module vpri_out_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_vld,
  input  vpri_pkg::result_t                res,
  output logic                             advance,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vpri_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import vpri_pkg::*;

  logic    valid_r;
  result_t res_r;

  // the result register takes a new item when empty or being drained
  assign advance = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_vld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_TDATA_W'(res_r);

endmodule

>>> rtl/video_port_register_interface.sv
// channel  dir  signals                      contents
// in       in   in_tvalid/tready/tdata/tuser one port access
// out      out  out_tvalid/tready/tdata      one result per access
//
// one access per cycle sustained while out_tready stays high; each access passes
// through the input register, then the result register, before its result is
// offered on out
// synchronous active-low reset clears the pair latches, pointer, palette index,
// frame flag and the copies of registers 14 and 15; in_tready is low in reset
// a stalled result holds; an empty input register still takes one more access,
// then in_tready drops until the result register drains
module video_port_register_interface #(
  parameter int REG_COUNT      = vpri_pkg::RegCountDef,
  parameter int VRAM_ADDR_BITS = vpri_pkg::VramAddrBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte
  input  logic [vpri_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] req_type
  input  logic [vpri_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] read_data, [8] vram_we, [25:9] vram_addr, [33:26] vram_byte,
  // [34] reg_we, [40:35] reg_num, [48:41] reg_val, [49] pal_we,
  // [53:50] pal_entry, [62:54] pal_color, [63] zero
  output logic [vpri_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import vpri_pkg::*;

  logic    advance;
  logic    item_vld;
  req_t    item;
  result_t res;

  vpri_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  vpri_engine #(
    .REG_COUNT      (REG_COUNT),
    .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .advance  (advance),
    .res      (res)
  );

  vpri_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
